// ===== hw/rtl/spo_pkg.sv =====
// Shared types and constants for the stepper position oscillator.
package spo_pkg;

    localparam int MOTORS_DEF = 2;
    localparam int STEPS_PER_REV_DEF = 200;
    localparam int POS_W = 8;
    localparam int SIZE_W = 3;

    typedef enum logic [1:0] {
        MODE_ENGAGE  = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_LOAD    = 2'd2,
        MODE_SET_DIR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_SLOT  = 2'd1,
        ERR_RANGE = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        REG_IN_USE    = 2'd0,
        REG_ENABLE    = 2'd1,
        REG_OSCILLATE = 2'd2,
        REG_STEP_SIZE = 2'd3
    } cfg_idx_t;

    typedef enum logic [SIZE_W-1:0] {
        SZ_FULL      = 3'd0,
        SZ_HALF      = 3'd1,
        SZ_QUARTER   = 3'd2,
        SZ_EIGHTH    = 3'd3,
        SZ_SIXTEENTH = 3'd4
    } step_size_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] cur_target;
        logic [POS_W-1:0] oth_target;
        logic             dir;
        logic             step;
    } motor_state_t;

endpackage

// ===== hw/rtl/spo_state_mem.sv =====
// Per-motor state memory: synchronous read with write forwarding, reset by valid bits.
module spo_state_mem
    import spo_pkg::*;
#(
    parameter int MOTORS = MOTORS_DEF,
    parameter int IDX_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_idx,
    output motor_state_t        rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_idx,
    input  motor_state_t        wr_data
);

    motor_state_t      mem [MOTORS];
    logic [MOTORS-1:0] valid_reg;
    motor_state_t      rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Forward a same-cycle write so back-to-back items on one motor see it.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && wr_idx == rd_idx) begin
                rd_data_reg <= wr_data;
            end else if (valid_reg[rd_idx]) begin
                rd_data_reg <= mem[rd_idx];
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/stepper_position_oscillator.sv =====
// Top level of the stepper position oscillator: command pipeline and result register.
// An accepted input beat passes through stage 1 (with the state memory read) into the result register.
// Throughput: one input beat per cycle unless a full result register waits on m_ready; set by the single
// read-modify-write of the per-motor state memory (forwarding covers back-to-back beats on one motor).
// Reset: aresetn (synchronous, active low) clears configuration, pipeline and result
// valids, and marks every state entry as zero through per-entry valid bits at once.
module stepper_position_oscillator
    import spo_pkg::*;
#(
    parameter int MOTORS        = MOTORS_DEF,
    parameter int STEPS_PER_REV = STEPS_PER_REV_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [3*MOTORS-1:0]   cfg_wdata,
    // command beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic                  s_motor,
    input  logic [POS_W-1:0]      s_target_a,
    input  logic [POS_W-1:0]      s_target_b,
    input  logic                  s_direction,
    // result beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_error,
    output logic                  m_step_out,
    output logic                  m_dir_out,
    output logic                  m_ms1_out,
    output logic                  m_ms2_out,
    output logic                  m_ms3_out,
    output logic                  m_enable_n_out,
    output logic [POS_W-1:0]      m_position,
    output logic [POS_W-1:0]      m_target_now
);

    localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int CFG_W = 3 * MOTORS;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(STEPS_PER_REV - 1);

    // Configuration registers; the user must write them only while the pipeline is idle (not enforced by the block).
    logic [MOTORS-1:0] in_use_reg;
    logic [MOTORS-1:0] enable_reg;
    logic [MOTORS-1:0] oscillate_reg;
    logic [CFG_W-1:0]  step_sizes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg     <= '0;
            enable_reg     <= '0;
            oscillate_reg  <= '0;
            step_sizes_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_IN_USE:    in_use_reg     <= cfg_wdata[MOTORS-1:0];
                REG_ENABLE:    enable_reg     <= cfg_wdata[MOTORS-1:0];
                REG_OSCILLATE: oscillate_reg  <= cfg_wdata[MOTORS-1:0];
                REG_STEP_SIZE: step_sizes_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Handshake: stage 1 advances whenever the result register is free or draining.
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg;
    logic s1_go;
    logic accept;

    assign s1_go   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_go;
    assign accept  = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage 1 command payload, captured alongside the memory read.
    mode_t            s1_mode_reg;
    logic             s1_motor_reg;
    logic [POS_W-1:0] s1_ta_reg;
    logic [POS_W-1:0] s1_tb_reg;
    logic             s1_dir_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mode_reg  <= mode_t'(s_mode);
            s1_motor_reg <= s_motor;
            s1_ta_reg    <= s_target_a;
            s1_tb_reg    <= s_target_b;
            s1_dir_reg   <= s_direction;
        end
    end

    // State memory: read on accept, written back when stage 1 advances with a usable slot.
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] s1_idx;
    motor_state_t     cur_st;
    motor_state_t     new_st;
    logic             wr_en;

    assign rd_idx = IDX_W'(s_motor);
    assign s1_idx = IDX_W'(s1_motor_reg);

    spo_state_mem #(
        .MOTORS (MOTORS),
        .IDX_W  (IDX_W)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_idx  (rd_idx),
        .rd_data (cur_st),
        .wr_en   (wr_en),
        .wr_idx  (s1_idx),
        .wr_data (new_st)
    );

    // Stage 1: modify the addressed motor's state.
    logic        in_range;
    logic        slot_ok;
    logic [1:0]  err;
    logic [SIZE_W-1:0] sz;

    assign in_range = (32'(s1_motor_reg) < MOTORS);

    always_comb begin
        new_st  = cur_st;
        err     = ERR_NONE;
        slot_ok = in_range && in_use_reg[s1_idx];
        if (!slot_ok) begin
            err = ERR_SLOT;
        end else begin
            unique case (s1_mode_reg)
                MODE_ENGAGE: begin
                    // Move one step in the direction given by dir only when enabled and not at the target yet.
                    if (enable_reg[s1_idx] && cur_st.position != cur_st.cur_target) begin
                        new_st.step = 1'b1;
                        if (!cur_st.dir) begin
                            new_st.position = (cur_st.position >= LAST_POS) ? '0
                                              : cur_st.position + POS_W'(1);
                        end else begin
                            new_st.position = (cur_st.position == '0 ||
                                               cur_st.position > LAST_POS) ? LAST_POS
                                              : cur_st.position - POS_W'(1);
                        end
                    end
                end
                MODE_RELEASE: begin
                    new_st.step = 1'b0;
                    // Oscillate: at the target, swap targets and reverse.
                    if (oscillate_reg[s1_idx] && cur_st.cur_target == cur_st.position) begin
                        new_st.cur_target = cur_st.oth_target;
                        new_st.oth_target = cur_st.cur_target;
                        new_st.dir        = ~cur_st.dir;
                    end
                end
                MODE_LOAD: begin
                    if (s1_ta_reg <= LAST_POS && s1_tb_reg <= LAST_POS) begin
                        new_st.cur_target = s1_ta_reg;
                        new_st.oth_target = s1_tb_reg;
                    end else begin
                        err = ERR_RANGE;
                    end
                end
                MODE_SET_DIR: begin
                    new_st.dir = s1_dir_reg;
                end
                default: ;
            endcase
        end
    end

    assign wr_en = s1_go && slot_ok;
    assign sz    = step_sizes_reg[SIZE_W*s1_idx +: SIZE_W];

    // Result register.
    logic [1:0]       m_error_reg;
    logic             m_step_reg, m_dir_reg, m_ms1_reg, m_ms2_reg, m_ms3_reg, m_en_n_reg;
    logic [POS_W-1:0] m_pos_reg, m_tgt_reg;
    logic             m_valid_next;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            m_error_reg <= err;
            if (in_range) begin
                m_step_reg <= new_st.step;
                m_dir_reg  <= new_st.dir;
                m_ms1_reg  <= (sz == SZ_HALF || sz == SZ_EIGHTH || sz == SZ_SIXTEENTH);
                m_ms2_reg  <= (sz == SZ_QUARTER || sz == SZ_EIGHTH || sz == SZ_SIXTEENTH);
                m_ms3_reg  <= (sz == SZ_SIXTEENTH);
                m_en_n_reg <= ~enable_reg[s1_idx];
                m_pos_reg  <= new_st.position;
                m_tgt_reg  <= new_st.cur_target;
            end else begin
                // Motor index past the last slot: every pin field reads zero.
                m_step_reg <= 1'b0;
                m_dir_reg  <= 1'b0;
                m_ms1_reg  <= 1'b0;
                m_ms2_reg  <= 1'b0;
                m_ms3_reg  <= 1'b0;
                m_en_n_reg <= 1'b0;
                m_pos_reg  <= '0;
                m_tgt_reg  <= '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_error        = m_error_reg;
    assign m_step_out     = m_step_reg;
    assign m_dir_out      = m_dir_reg;
    assign m_ms1_out      = m_ms1_reg;
    assign m_ms2_out      = m_ms2_reg;
    assign m_ms3_out      = m_ms3_reg;
    assign m_enable_n_out = m_en_n_reg;
    assign m_position     = m_pos_reg;
    assign m_target_now   = m_tgt_reg;

endmodule
